/* design/ptts_pkg.sv */
`default_nettype none

package ptts_pkg;

   // Command codes of the request channel
   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_DISPATCH = 2'd1;
   localparam logic [1:0] CMD_ADD      = 2'd2;

   // Result kinds
   localparam logic [2:0] KIND_TICK_DONE  = 3'd0;
   localparam logic [2:0] KIND_ADDED      = 3'd1;
   localparam logic [2:0] KIND_TABLE_FULL = 3'd2;
   localparam logic [2:0] KIND_DUE        = 3'd3;
   localparam logic [2:0] KIND_NONE_DUE   = 3'd4;

   // Most due tasks reported by one dispatch
   localparam int DISPATCH_CAP = 8;

   localparam int MS_W      = 16;
   localparam int COUNTER_W = 18;

   typedef struct packed {
      logic [1:0]      cmd;
      logic [MS_W-1:0] period_ms;
      logic [MS_W-1:0] offset_ms;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] task_index;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_WALK,
      ST_DISPATCH,
      ST_ADD_PERIOD,
      ST_ADD_OFFSET,
      ST_ADD_WRITE,
      ST_REPORT
   } state_type;

endpackage

`default_nettype wire

/* design/ptts_tick_div.sv */
`default_nettype none

// Divide a millisecond value by the tick length: multiply by a rounded-up
// reciprocal and shift. Exact for every 16-bit dividend; registered output.
module ptts_tick_div #(
   parameter int TICK_MS = 1
) (
   input  wire logic                     clock,
   input  wire logic [ptts_pkg::MS_W-1:0] dividend,
   output logic      [ptts_pkg::MS_W-1:0] quotient_ff
);

   localparam int SHIFT = ptts_pkg::MS_W + $clog2(TICK_MS);
   localparam int PROD_W = 2 * ptts_pkg::MS_W + 1;
   localparam logic [ptts_pkg::MS_W:0] RECIP =
      (ptts_pkg::MS_W + 1)'(((64'd1 << SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

   logic [PROD_W-1:0] product;
   logic [PROD_W-1:0] shifted;

   assign product = PROD_W'(dividend) * PROD_W'(RECIP);
   assign shifted = product >> SHIFT;

   // Register the quotient
   always_ff @(posedge clock) begin
      quotient_ff <= shifted[ptts_pkg::MS_W-1:0];
   end

endmodule

`default_nettype wire

/* design/periodic_task_tick_scheduler.sv */
`default_nettype none

// Periodic task tick scheduler. Holds up to MAX_TASKS task slots, filled in
// order; each slot's period and 18-bit signed down counter live in one
// single-port-read synchronous memory of MAX_TASKS entries, and the ready
// flags sit in flip-flops. Requests are taken one at a time, only while the
// scheduler is idle; a finished result may still wait on rsp_stall while
// the next request is taken. A tick walks every installed slot through the
// memory with one read-modify-write per cycle, then waits on result
// back-pressure; with no slot installed it skips the walk. An add runs the
// two millisecond values through one shared reciprocal multiplier, one per
// cycle. A dispatch scans the ready flags one slot per cycle, pausing on a
// due slot while rsp_stall holds the result, up to the last due task it
// reports, one result per due task, at most eight. The memory needs no
// clearing pass: entries above the fill count are never read.
module periodic_task_tick_scheduler #(
   parameter int MAX_TASKS = 8,
   parameter int TICK_MS   = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ptts_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ptts_pkg::rsp_type      rsp_data
);

   localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W   = $clog2(MAX_TASKS + 1);
   localparam int SENT_W  = $clog2(ptts_pkg::DISPATCH_CAP);
   localparam int MS_W    = ptts_pkg::MS_W;
   localparam int CTR_W   = ptts_pkg::COUNTER_W;
   localparam int ENTRY_W = MS_W + CTR_W;

   ptts_pkg::state_type state_ff, state_in;

   ptts_pkg::req_type   req_ff;
   logic [CNT_W-1:0]    slots_ff, slots_in;
   logic [CNT_W-1:0]    walk_ff, walk_in;
   logic [SENT_W-1:0]   sent_ff, sent_in;
   logic [MAX_TASKS-1:0] flags_ff, flags_in;
   logic [MS_W-1:0]     period_ff, period_in;
   logic [2:0]          report_ff, report_in;
   logic                rsp_valid_ff;
   ptts_pkg::rsp_type   rsp_data_ff;

   logic [ENTRY_W-1:0]  slot_mem [MAX_TASKS];
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]  wr_data;

   logic                req_accept;
   logic                out_free;
   logic                emit_valid;
   ptts_pkg::rsp_type   emit_data;

   logic [IDX_W-1:0]    walk_idx;
   logic [IDX_W-1:0]    slot_idx;
   logic [CNT_W-1:0]    walk_nx;
   logic                table_full;
   logic                walk_end;
   logic [MAX_TASKS-1:0] above_mask;
   logic                dispatch_last;

   logic [MS_W-1:0]     div_in;
   logic [MS_W-1:0]     div_q;

   logic signed [CTR_W-1:0] ctr_old;
   logic signed [CTR_W-1:0] ctr_dec;
   logic                ctr_reload;

   assign req_stall  = (state_ff != ptts_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign walk_idx   = walk_ff[IDX_W-1:0];
   assign slot_idx   = slots_ff[IDX_W-1:0];
   assign walk_nx    = walk_ff + CNT_W'(1);
   assign table_full = (slots_ff == CNT_W'(MAX_TASKS));
   assign walk_end   = (walk_nx == slots_ff);

   // Mark slots above the current walk position
   always_comb begin
      for (int j = 0; j < MAX_TASKS; j++) begin
         above_mask[j] = (IDX_W'(j) > walk_idx);
      end
   end

   assign dispatch_last = (sent_ff == SENT_W'(ptts_pkg::DISPATCH_CAP - 1))
                          || !(|(flags_ff & above_mask));

   // Decrement the counter read from memory, reload at zero or below
   assign ctr_old    = $signed(rd_data_ff[CTR_W-1:0]);
   assign ctr_dec    = ctr_old - CTR_W'(1);
   assign ctr_reload = ctr_dec[CTR_W-1] || (ctr_dec == '0);

   // Share one divider between period and offset
   assign div_in = (state_ff == ptts_pkg::ST_ADD_PERIOD) ? req_ff.period_ms
                                                         : req_ff.offset_ms;

   ptts_tick_div #(
      .TICK_MS (TICK_MS)
   ) u_div (
      .clock       (clock),
      .dividend    (div_in),
      .quotient_ff (div_q)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptts_pkg::ST_IDLE: begin
            if (req_accept) begin
               priority case (req_data.cmd)
                  ptts_pkg::CMD_TICK:
                     state_in = (slots_ff == '0) ? ptts_pkg::ST_REPORT
                                                 : ptts_pkg::ST_TICK_WALK;
                  ptts_pkg::CMD_DISPATCH:
                     state_in = (flags_ff == '0) ? ptts_pkg::ST_REPORT
                                                 : ptts_pkg::ST_DISPATCH;
                  ptts_pkg::CMD_ADD:
                     state_in = table_full ? ptts_pkg::ST_REPORT
                                           : ptts_pkg::ST_ADD_PERIOD;
                  default:
                     state_in = ptts_pkg::ST_IDLE;
               endcase
            end
         end
         ptts_pkg::ST_TICK_WALK: begin
            if (walk_end) state_in = ptts_pkg::ST_REPORT;
         end
         ptts_pkg::ST_DISPATCH: begin
            if (flags_ff[walk_idx] && out_free && dispatch_last) begin
               state_in = ptts_pkg::ST_IDLE;
            end
         end
         ptts_pkg::ST_ADD_PERIOD: state_in = ptts_pkg::ST_ADD_OFFSET;
         ptts_pkg::ST_ADD_OFFSET: state_in = ptts_pkg::ST_ADD_WRITE;
         ptts_pkg::ST_ADD_WRITE: begin
            if (out_free) state_in = ptts_pkg::ST_IDLE;
         end
         ptts_pkg::ST_REPORT: begin
            if (out_free) state_in = ptts_pkg::ST_IDLE;
         end
         default: state_in = ptts_pkg::ST_IDLE;
      endcase
   end

   // Datapath control and results
   always_comb begin
      slots_in   = slots_ff;
      walk_in    = walk_ff;
      sent_in    = sent_ff;
      flags_in   = flags_ff;
      period_in  = period_ff;
      report_in  = report_ff;
      rd_en      = 1'b0;
      rd_addr    = walk_nx[IDX_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = walk_idx;
      wr_data    = {rd_data_ff[ENTRY_W-1:CTR_W], ctr_dec};
      emit_valid = 1'b0;
      emit_data  = '{kind: ptts_pkg::KIND_TICK_DONE, task_index: 3'd0, last: 1'b1};

      unique case (state_ff)
         ptts_pkg::ST_IDLE: begin
            walk_in = '0;
            sent_in = '0;
            if (req_accept) begin
               priority case (req_data.cmd)
                  ptts_pkg::CMD_TICK: begin
                     report_in = ptts_pkg::KIND_TICK_DONE;
                     rd_en     = (slots_ff != '0);
                     rd_addr   = '0;
                  end
                  ptts_pkg::CMD_DISPATCH: report_in = ptts_pkg::KIND_NONE_DUE;
                  ptts_pkg::CMD_ADD:      report_in = ptts_pkg::KIND_TABLE_FULL;
                  default:                report_in = report_ff;
               endcase
            end
         end
         ptts_pkg::ST_TICK_WALK: begin
            // Write back this slot, read the next one
            wr_en = 1'b1;
            if (ctr_reload) begin
               wr_data            = {rd_data_ff[ENTRY_W-1:CTR_W], CTR_W'(rd_data_ff[ENTRY_W-1:CTR_W])};
               flags_in[walk_idx] = 1'b1;
            end
            rd_en   = !walk_end;
            walk_in = walk_nx;
         end
         ptts_pkg::ST_DISPATCH: begin
            if (flags_ff[walk_idx]) begin
               if (out_free) begin
                  emit_valid         = 1'b1;
                  emit_data.kind     = ptts_pkg::KIND_DUE;
                  emit_data.task_index = 3'(walk_idx);
                  emit_data.last     = dispatch_last;
                  flags_in[walk_idx] = 1'b0;
                  sent_in            = sent_ff + SENT_W'(1);
                  walk_in            = walk_nx;
               end
            end else begin
               walk_in = walk_nx;
            end
         end
         ptts_pkg::ST_ADD_PERIOD: begin
            period_in = period_ff;
         end
         ptts_pkg::ST_ADD_OFFSET: begin
            // Capture the period quotient while the offset is divided
            period_in = div_q;
         end
         ptts_pkg::ST_ADD_WRITE: begin
            if (out_free) begin
               wr_en                = 1'b1;
               wr_addr              = slot_idx;
               wr_data              = {period_ff, CTR_W'(period_ff) - CTR_W'(div_q)};
               flags_in[slot_idx]   = 1'b0;
               slots_in             = slots_ff + CNT_W'(1);
               emit_valid           = 1'b1;
               emit_data.kind       = ptts_pkg::KIND_ADDED;
               emit_data.task_index = 3'(slot_idx);
               emit_data.last       = 1'b1;
            end
         end
         ptts_pkg::ST_REPORT: begin
            if (out_free) begin
               emit_valid     = 1'b1;
               emit_data.kind = report_ff;
            end
         end
         default: begin
            emit_valid = 1'b0;
         end
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptts_pkg::ST_IDLE;
         slots_ff     <= '0;
         flags_ff     <= '0;
         walk_ff      <= '0;
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slots_ff <= slots_in;
         flags_ff <= flags_in;
         walk_ff  <= walk_in;
         sent_ff  <= sent_in;
         if (out_free) rsp_valid_ff <= emit_valid;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      period_ff <= period_in;
      report_ff <= report_in;
      if (req_accept) req_ff <= req_data;
      if (out_free && emit_valid) rsp_data_ff <= emit_data;
   end

   // Slot memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) slot_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= slot_mem[rd_addr];
   end

endmodule

`default_nettype wire
